/* rtl/rac_pkg.sv */
// Package for the masked tile colour averager: widths, register map, mode codes and the
// types shared by the configuration block, the pixel front end, the queue and the back end.
// Depends on nothing.
package rac_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int DIM_W      = COORD_W + 1;
  localparam int CHAN_W     = 8;
  localparam int MODE_W     = 3;
  localparam int SUM_W      = 32;
  localparam int MEAN_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int NUM_CH     = 3;
  // largest divisor is the widest masked tile size squared
  localparam int DIVR_W     = 2 * DIM_W;
  localparam int DVD_W      = SUM_W + FRAC_W + 1;
  localparam int CNT_W      = $clog2(DVD_W);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int REG_IDX_W  = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_START_ROW = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_COL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TILE_ROWS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILE_COLS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RECT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRI_UPPER = 3'd1;  // above the anti-diagonal
  localparam logic [MODE_W-1:0] MODE_TRI_LOWER = 3'd2;  // on or below the anti-diagonal
  localparam logic [MODE_W-1:0] MODE_TRI_RIGHT = 3'd3;  // on or right of the diagonal
  localparam logic [MODE_W-1:0] MODE_TRI_LEFT  = 3'd4;  // left of the diagonal

  typedef struct packed {
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [DIM_W-1:0]   tile_rows;
    logic [DIM_W-1:0]   tile_cols;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last;
  } pix_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/rac_if.sv */
// Channel interfaces of the tile colour averager: pixel input and mean result.
// Depends on rac_pkg.
interface rac_pix_if;
  logic                         valid;
  logic                         ready;
  logic [rac_pkg::COORD_W-1:0]  pixel_row;
  logic [rac_pkg::COORD_W-1:0]  pixel_col;
  logic [rac_pkg::CHAN_W-1:0]   blue_in;
  logic [rac_pkg::CHAN_W-1:0]   green_in;
  logic [rac_pkg::CHAN_W-1:0]   red_in;
  logic                         frame_end;

  modport source (output valid, pixel_row, pixel_col, blue_in, green_in, red_in, frame_end,
                  input ready);
  modport sink   (input valid, pixel_row, pixel_col, blue_in, green_in, red_in, frame_end,
                  output ready);
endinterface

interface rac_mean_if;
  logic                        valid;
  logic                        ready;
  logic [rac_pkg::MEAN_W-1:0]  mean_blue;
  logic [rac_pkg::MEAN_W-1:0]  mean_green;
  logic [rac_pkg::MEAN_W-1:0]  mean_red;
  logic                        zero_area;

  modport source (output valid, mean_blue, mean_green, mean_red, zero_area, input ready);
  modport sink   (input valid, mean_blue, mean_green, mean_red, zero_area, output ready);
endinterface

/* rtl/rac_cfg.sv */
// Register file of the tile colour averager behind an APB-style port.
// Depends on rac_pkg.
module rac_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rac_pkg::CFG_AW-1:0]  paddr,
  input  logic [rac_pkg::CFG_DW-1:0]  pwdata,
  output logic [rac_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output rac_pkg::cfg_t               cfg
);

  rac_pkg::cfg_t                  cfg_r;
  logic [rac_pkg::REG_IDX_W-1:0]  idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[rac_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        rac_pkg::REG_START_ROW: cfg_r.start_row <= pwdata[rac_pkg::COORD_W-1:0];
        rac_pkg::REG_START_COL: cfg_r.start_col <= pwdata[rac_pkg::COORD_W-1:0];
        rac_pkg::REG_TILE_ROWS: cfg_r.tile_rows <= pwdata[rac_pkg::DIM_W-1:0];
        rac_pkg::REG_TILE_COLS: cfg_r.tile_cols <= pwdata[rac_pkg::DIM_W-1:0];
        rac_pkg::REG_MODE:      cfg_r.mode      <= pwdata[rac_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rac_pkg::REG_START_ROW: prdata = rac_pkg::CFG_DW'(cfg_r.start_row);
      rac_pkg::REG_START_COL: prdata = rac_pkg::CFG_DW'(cfg_r.start_col);
      rac_pkg::REG_TILE_ROWS: prdata = rac_pkg::CFG_DW'(cfg_r.tile_rows);
      rac_pkg::REG_TILE_COLS: prdata = rac_pkg::CFG_DW'(cfg_r.tile_cols);
      rac_pkg::REG_MODE:      prdata = rac_pkg::CFG_DW'(cfg_r.mode);
      default:                prdata = '0;
    endcase
  end

endmodule

/* rtl/rac_fifo.sv */
// Short queue of classified pixels between the front end and the back end.
// Depends on rac_pkg.
module rac_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rac_pkg::pix_ent_t   push_data,
  input  logic                pop,
  output rac_pkg::pix_ent_t   pop_data,
  output rac_pkg::q_stat_t    stat
);

  rac_pkg::pix_ent_t            mem_r [rac_pkg::FIFO_DEPTH];
  logic [rac_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [rac_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [rac_pkg::FIFO_AW:0]    cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign stat.full  = (cnt_r == (rac_pkg::FIFO_AW+1)'(rac_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/rac_front.sv */
// Pixel front end: accept, test against the tile and mask, stage and queue.
// Depends on rac_pkg and rac_if.
module rac_front (
  input  logic               clk,
  input  logic               rst_n,
  rac_pix_if.sink            in_ch,
  input  rac_pkg::cfg_t      cfg,
  input  rac_pkg::q_stat_t   q_stat,
  output logic               push,
  output rac_pkg::pix_ent_t  push_data
);

  logic [rac_pkg::DIM_W-1:0]  r_d;
  logic [rac_pkg::DIM_W-1:0]  c_d;
  logic [rac_pkg::DIM_W:0]    diag;
  logic                       in_tile;
  logic                       hit;
  logic                       keep;
  rac_pkg::pix_ent_t          ent;
  rac_pkg::pix_ent_t          stg_r;
  logic                       stg_valid_r;

  always_comb begin
    r_d     = {1'b0, in_ch.pixel_row} - {1'b0, cfg.start_row};
    c_d     = {1'b0, in_ch.pixel_col} - {1'b0, cfg.start_col};
    diag    = {1'b0, r_d} + {1'b0, c_d};
    in_tile = (in_ch.pixel_row >= cfg.start_row) && (r_d < cfg.tile_rows) &&
              (in_ch.pixel_col >= cfg.start_col) && (c_d < cfg.tile_cols);
    case (cfg.mode)
      rac_pkg::MODE_RECT:      hit = in_tile;
      rac_pkg::MODE_TRI_UPPER: hit = in_tile && (diag <  {1'b0, cfg.tile_cols});
      rac_pkg::MODE_TRI_LOWER: hit = in_tile && (diag >= {1'b0, cfg.tile_cols});
      rac_pkg::MODE_TRI_RIGHT: hit = in_tile && (c_d >= r_d);
      rac_pkg::MODE_TRI_LEFT:  hit = in_tile && (c_d <  r_d);
      default:                 hit = 1'b0;
    endcase
    // drop pixels that neither count nor close the frame
    keep      = hit || in_ch.frame_end;
    ent.blue  = hit ? in_ch.blue_in  : '0;
    ent.green = hit ? in_ch.green_in : '0;
    ent.red   = hit ? in_ch.red_in   : '0;
    ent.last  = in_ch.frame_end;
  end

  assign in_ch.ready = !stg_valid_r || !q_stat.full;
  assign push        = stg_valid_r && !q_stat.full;
  assign push_data   = stg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) stg_r <= ent;
  end

endmodule

/* rtl/rac_back.sv */
// Back end: accumulate channel sums, divide at frame end, hold the result register.
// Depends on rac_pkg and rac_if.
module rac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rac_pkg::cfg_t      cfg,
  input  rac_pkg::q_stat_t   q_stat,
  input  rac_pkg::pix_ent_t  q_data,
  output logic               pop,
  rac_mean_if.source         out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } bk_state_t;

  bk_state_t                     state_r;
  bk_state_t                     state_nxt;
  logic [rac_pkg::SUM_W-1:0]     sum_r    [rac_pkg::NUM_CH];
  logic [rac_pkg::SUM_W-1:0]     sum_fin  [rac_pkg::NUM_CH];
  logic [rac_pkg::SUM_W-1:0]     sum_nxt  [rac_pkg::NUM_CH];
  logic [rac_pkg::CHAN_W-1:0]    chan     [rac_pkg::NUM_CH];
  logic [rac_pkg::DVD_W-1:0]     dq_r     [rac_pkg::NUM_CH];
  logic [rac_pkg::DIVR_W-1:0]    rem_r    [rac_pkg::NUM_CH];
  logic [rac_pkg::DIVR_W:0]      trial    [rac_pkg::NUM_CH];
  logic [rac_pkg::DIVR_W-1:0]    rem_nxt  [rac_pkg::NUM_CH];
  logic                          ge       [rac_pkg::NUM_CH];
  logic [rac_pkg::MEAN_W-1:0]    mean_sat [rac_pkg::NUM_CH];
  logic [rac_pkg::MEAN_W-1:0]    mean_r   [rac_pkg::NUM_CH];
  logic [2*rac_pkg::DIM_W-1:0]   area;
  logic [rac_pkg::DIVR_W-1:0]    div_r;
  logic [rac_pkg::CNT_W-1:0]     cnt_r;
  logic                          zero_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_load;
  logic                          close;

  assign chan[0] = q_data.blue;
  assign chan[1] = q_data.green;
  assign chan[2] = q_data.red;

  assign area = cfg.tile_rows * cfg.tile_cols;

  always_comb begin
    pop       = !q_stat.empty && (!q_data.last || state_r == S_IDLE);
    close     = pop && q_data.last;
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (close) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_DIV;
      S_DIV:   if (cnt_r == rac_pkg::CNT_W'(rac_pkg::DVD_W - 1)) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);
    for (int i = 0; i < rac_pkg::NUM_CH; i++) begin
      sum_fin[i] = sum_r[i] + rac_pkg::SUM_W'(chan[i]);
      sum_nxt[i] = !pop ? sum_r[i] : (q_data.last ? '0 : sum_fin[i]);
      trial[i]   = {rem_r[i], dq_r[i][rac_pkg::DVD_W-1]};
      ge[i]      = (trial[i] >= {1'b0, div_r});
      rem_nxt[i] = ge[i] ? rac_pkg::DIVR_W'(trial[i] - {1'b0, div_r})
                         : trial[i][rac_pkg::DIVR_W-1:0];
      mean_sat[i] = (|dq_r[i][rac_pkg::DVD_W-1:rac_pkg::MEAN_W]) ? '1
                                                                : dq_r[i][rac_pkg::MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rac_pkg::NUM_CH; i++) sum_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < rac_pkg::NUM_CH; i++) sum_r[i] <= sum_nxt[i];
    end
  end

  // divisor follows the static configuration
  always_ff @(posedge clk) begin
    if (cfg.mode == rac_pkg::MODE_RECT) begin
      div_r <= area[rac_pkg::DIVR_W-1:0];
    end else begin
      div_r <= {1'b0, area[rac_pkg::DIVR_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (close) begin
          for (int i = 0; i < rac_pkg::NUM_CH; i++) begin
            dq_r[i] <= {1'b0, sum_fin[i], {rac_pkg::FRAC_W{1'b0}}};
          end
        end
      end
      S_PREP: begin
        cnt_r <= '0;
        for (int i = 0; i < rac_pkg::NUM_CH; i++) begin
          dq_r[i]  <= dq_r[i] + rac_pkg::DVD_W'(div_r >> 1);
          rem_r[i] <= '0;
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < rac_pkg::NUM_CH; i++) begin
          dq_r[i]  <= {dq_r[i][rac_pkg::DVD_W-2:0], ge[i]};
          rem_r[i] <= rem_nxt[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      zero_r <= (div_r == '0);
      for (int i = 0; i < rac_pkg::NUM_CH; i++) begin
        mean_r[i] <= (div_r == '0) ? '0 : mean_sat[i];
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mean_blue  = mean_r[0];
  assign out_ch.mean_green = mean_r[1];
  assign out_ch.mean_red   = mean_r[2];
  assign out_ch.zero_area  = zero_r;

endmodule

/* rtl/region_average_color.sv */
// Top level of the masked tile colour averager: register file, front end, queue, back end.
// Depends on rac_pkg, rac_if, rac_cfg, rac_front, rac_fifo and rac_back.
//
//   port group   direction  transaction
//   in_ch        sink       one pixel: row, column, blue, green, red, frame end mark
//   out_ch       source     one result: three 8.8 means and the zero-area flag
//   APB (p*)     slave      one register write or read, registers at byte address 4*index
//
// The front end takes one pixel per cycle while the queue has room; pixels that miss the
// tile or its mask are dropped there. The back end adds each counted pixel as it pops it.
// A frame-end pixel takes the back end through closing the sums, adding the rounding
// half, the restoring divider (one quotient bit a cycle, three channels side by side) and
// loading the result register. The front end keeps taking pixels into the four-entry
// queue meanwhile, and the back end resumes summing straight after closing the sums, so
// only a second frame end waits, until the result register is loaded.
// Reset (rst_n low at a clock edge) clears the registers, sums, queue and result valid.
// A stalled result holds in its register; the divider then waits before loading it.
module region_average_color (
  input  logic                        clk,
  input  logic                        rst_n,
  rac_pix_if.sink                     in_ch,
  rac_mean_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rac_pkg::CFG_AW-1:0]  paddr,
  input  logic [rac_pkg::CFG_DW-1:0]  pwdata,
  output logic [rac_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  rac_pkg::cfg_t      cfg;
  rac_pkg::q_stat_t   q_stat;
  rac_pkg::pix_ent_t  push_data;
  rac_pkg::pix_ent_t  pop_data;
  logic               push;
  logic               pop;

  // configuration registers; written by the user only while the block is idle, unenforced
  rac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classify each pixel against the tile and mask, stage it, push it
  rac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouple the front end from the divider's long stalls
  rac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // accumulate, divide at frame end, hold the result
  rac_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_data (pop_data),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* rtl/rac_checker.sv */
// Port-level checks of the tile colour averager, bound to the top level.
// Depends on rac_pkg and region_average_color.
module rac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rac_pkg::MEAN_W-1:0]  mean_blue,
  input logic [rac_pkg::MEAN_W-1:0]  mean_green,
  input logic [rac_pkg::MEAN_W-1:0]  mean_red,
  input logic                        zero_area,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready,
  input logic [rac_pkg::CFG_AW-1:0]  paddr,
  input logic [rac_pkg::CFG_DW-1:0]  pwdata,
  input logic [rac_pkg::CFG_DW-1:0]  prdata
);

  logic                       mode_wr;
  logic [rac_pkg::CFG_AW-1:0] mode_addr;

  assign mode_addr = {rac_pkg::REG_MODE, 2'b00};
  assign mode_wr   = psel && penable && pwrite && pready && (paddr == mode_addr);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mean_blue) && $stable(mean_green)
                                && $stable(mean_red) && $stable(zero_area))
    else $error("result changed while stalled");

  // a zero divisor gives zero means
  a_zero_means: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_area |-> mean_blue == '0 && mean_green == '0 && mean_red == '0)
    else $error("zero area with nonzero mean");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // the mode register reads back what was last written
  a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(mode_wr) && paddr == mode_addr
      |-> prdata[rac_pkg::MODE_W-1:0] == $past(pwdata[rac_pkg::MODE_W-1:0]))
    else $error("mode register read-back mismatch");

endmodule

bind region_average_color rac_checker u_rac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .mean_blue  (out_ch.mean_blue),
  .mean_green (out_ch.mean_green),
  .mean_red   (out_ch.mean_red),
  .zero_area  (out_ch.zero_area),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .pready     (pready),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

/* sim/region_average_color_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for region_average_color: pixel transactions in, mean results out,
// tile registers over the APB port. Depends on rac_pkg, rac_if and the region_average_color RTL.
module region_average_color_test;
  import rac_pkg::*;

  localparam int CLK_PERIOD   = 8;
  // a frame end keeps the back end busy through the divider; add room for the four-entry queue
  localparam int DRAIN_CYCLES = 64;
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int REPORT_LIMIT = 10;

  // register indexes past the map, and mode codes that mask everything out
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_VOID_FIRST = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_VOID_LAST  = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [MEAN_W-1:0] blue;
    logic [MEAN_W-1:0] green;
    logic [MEAN_W-1:0] red;
    logic              zero_area;
  } mean_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  rac_pix_if  pix_ch ();
  rac_mean_if mean_ch ();

  region_average_color DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_ch),
    .out_ch  (mean_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted tile registers and running channel totals
  cfg_t              tile_cfg;
  logic [SUM_W-1:0]  blue_total;
  logic [SUM_W-1:0]  green_total;
  logic [SUM_W-1:0]  red_total;

  pixel_t      pixel_queue[$];     // pixels waiting for the driver
  mean_t       expected_means[$];  // predicted results, oldest first
  int unsigned pixels_queued;
  int unsigned pixels_accepted;
  int unsigned mismatch_count;

  bit          in_taken;    // a pixel transaction completed at the last rising edge
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_pct;    // chance per cycle of starting an idle burst
  bit          calm_tail;   // no idling on either side

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Decide whether a pixel lies inside the tile and passes the selected mask.
  function automatic bit pixel_in_mask(pixel_t p);
    int r, c, h, w;
    r = int'(p.row) - int'(tile_cfg.start_row);
    c = int'(p.col) - int'(tile_cfg.start_col);
    h = int'(tile_cfg.tile_rows);
    w = int'(tile_cfg.tile_cols);
    if (r < 0 || r >= h || c < 0 || c >= w) return 1'b0;
    case (tile_cfg.mode)
      MODE_RECT:      return 1'b1;
      MODE_TRI_UPPER: return c < w - r;
      MODE_TRI_LOWER: return c >= w - r;
      MODE_TRI_RIGHT: return c >= r;
      MODE_TRI_LEFT:  return c < r;
      default:        return 1'b0;
    endcase
  endfunction

  // Round to nearest, ties upward, then saturate to the 8.8 range.
  function automatic logic [MEAN_W-1:0] rounded_mean(logic [SUM_W-1:0] total,
                                                     longint unsigned divisor);
    longint unsigned wide, q;
    wide = total;
    q = (wide * 256 + divisor / 2) / divisor;
    return (q > 65535) ? 16'hFFFF : q[MEAN_W-1:0];
  endfunction

  // Add one accepted pixel to the totals; on a frame end work out the means and clear.
  function automatic bit accumulate_pixel(pixel_t p, output mean_t res);
    longint unsigned divisor;
    res = '0;
    if (pixel_in_mask(p)) begin
      blue_total  = blue_total + p.blue;
      green_total = green_total + p.green;
      red_total   = red_total + p.red;
    end
    if (!p.last) return 1'b0;
    divisor = tile_cfg.tile_rows;
    divisor = divisor * tile_cfg.tile_cols;
    if (tile_cfg.mode != MODE_RECT) divisor = divisor / 2;
    if (divisor == 0) begin
      res.zero_area = 1'b1;
    end else begin
      res.blue  = rounded_mean(blue_total, divisor);
      res.green = rounded_mean(green_total, divisor);
      res.red   = rounded_mean(red_total, divisor);
    end
    blue_total  = '0;
    green_total = '0;
    red_total   = '0;
    return 1'b1;
  endfunction

  function automatic logic [CFG_DW-1:0] register_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_START_ROW: return CFG_DW'(tile_cfg.start_row);
      REG_START_COL: return CFG_DW'(tile_cfg.start_col);
      REG_TILE_ROWS: return CFG_DW'(tile_cfg.tile_rows);
      REG_TILE_COLS: return CFG_DW'(tile_cfg.tile_cols);
      REG_MODE:      return CFG_DW'(tile_cfg.mode);
      default:       return '0;
    endcase
  endfunction

  task automatic note_mismatch(string what);
    if (mismatch_count < REPORT_LIMIT) $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check a result before predicting
  // from a pixel taken at the same edge, since that pixel cannot have caused it yet.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    mean_t  got, want, res;
    pixel_t p;
    in_taken <= rst_n && pix_ch.valid && pix_ch.ready;
    if (rst_n) begin
      if (mean_ch.valid && mean_ch.ready) begin
        got = '{mean_ch.mean_blue, mean_ch.mean_green, mean_ch.mean_red, mean_ch.zero_area};
        if (expected_means.size() == 0) begin
          note_mismatch($sformatf("result with none expected: b=%h g=%h r=%h z=%b",
                                  got.blue, got.green, got.red, got.zero_area));
        end else begin
          want = expected_means.pop_front();
          if (got.blue !== want.blue || got.green !== want.green ||
              got.red !== want.red || got.zero_area !== want.zero_area) begin
            note_mismatch($sformatf(
              "expected b=%h g=%h r=%h z=%b, got b=%h g=%h r=%h z=%b",
              want.blue, want.green, want.red, want.zero_area,
              got.blue, got.green, got.red, got.zero_area));
          end
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        p = '{pix_ch.pixel_row, pix_ch.pixel_col, pix_ch.blue_in, pix_ch.green_in,
              pix_ch.red_in, pix_ch.frame_end};
        pixels_accepted++;
        if (accumulate_pixel(p, res)) expected_means.push_back(res);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pixel driver: change at the falling edge. Hold a transaction until it is taken, then
  // either start an idle burst or present the next pending pixel.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (pix_ch.valid && !in_taken) begin
      // hold the current transaction
    end else if (send_gap != 0) begin
      send_gap--;
      pix_ch.valid <= 1'b0;
    end else if (!calm_tail && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      send_gap = $urandom_range(8, 0);
      pix_ch.valid <= 1'b0;
    end else if (pixel_queue.size() != 0) begin
      nxt = pixel_queue.pop_front();
      pix_ch.valid     <= 1'b1;
      pix_ch.pixel_row <= nxt.row;
      pix_ch.pixel_col <= nxt.col;
      pix_ch.blue_in   <= nxt.blue;
      pix_ch.green_in  <= nxt.green;
      pix_ch.red_in    <= nxt.red;
      pix_ch.frame_end <= nxt.last;
    end else begin
      pix_ch.valid <= 1'b0;
    end
  end

  // Result side: stall in random bursts, none in the tail.
  always @(negedge clk) begin : drive_ready
    if (calm_tail) begin
      mean_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      mean_ch.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      stall_left = $urandom_range(8, 0);
      mean_ch.ready <= 1'b0;
    end else begin
      mean_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Register access: setup cycle, access cycle, wait for pready at the rising edge.
  // Update the predicted registers once the write has landed.
  // ---------------------------------------------------------------------------------------
  task automatic apb_cycle(input bit wr, input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr) begin
      case (idx)
        REG_START_ROW: tile_cfg.start_row = wdata[COORD_W-1:0];
        REG_START_COL: tile_cfg.start_col = wdata[COORD_W-1:0];
        REG_TILE_ROWS: tile_cfg.tile_rows = wdata[DIM_W-1:0];
        REG_TILE_COLS: tile_cfg.tile_cols = wdata[DIM_W-1:0];
        REG_MODE:      tile_cfg.mode      = wdata[MODE_W-1:0];
        default: ;  // spare index: drop the write
      endcase
    end
  endtask

  // Read back every register and compare with the predicted value.
  task automatic verify_registers();
    logic [CFG_DW-1:0] rd;
    for (int i = REG_START_ROW; i <= REG_MODE; i++) begin
      apb_cycle(1'b0, REG_IDX_W'(i), '0, rd);
      if (rd !== register_value(REG_IDX_W'(i)))
        note_mismatch($sformatf("register %0d read %h, expected %h", i, rd,
                                register_value(REG_IDX_W'(i))));
    end
  endtask

  task automatic program_tile(input logic [CFG_DW-1:0] srow, scol, rows, cols, mode);
    logic [CFG_DW-1:0] unused;
    apb_cycle(1'b1, REG_START_ROW, srow, unused);
    apb_cycle(1'b1, REG_START_COL, scol, unused);
    apb_cycle(1'b1, REG_TILE_ROWS, rows, unused);
    apb_cycle(1'b1, REG_TILE_COLS, cols, unused);
    apb_cycle(1'b1, REG_MODE, mode, unused);
    verify_registers();
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------
  task automatic queue_pixel(input logic [COORD_W-1:0] row, col,
                             input logic [CHAN_W-1:0] b, g, r, input logic last);
    pixel_queue.push_back('{row, col, b, g, r, last});
    pixels_queued++;
  endtask

  // Wait until every pixel is taken and every result has come, then let the back end
  // finish any pixels that carried no frame end.
  task automatic settle();
    while (pixels_accepted != pixels_queued || expected_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(255, 0));
    endcase
  endfunction

  // Mostly pixels inside the tile; the rest anywhere in the image.
  task automatic queue_random_pixel(input logic last);
    logic [COORD_W-1:0] row, col;
    if (tile_cfg.tile_rows != 0 && tile_cfg.tile_cols != 0 && $urandom_range(99, 0) < 85) begin
      row = tile_cfg.start_row + COORD_W'($urandom_range(tile_cfg.tile_rows - 1, 0));
      col = tile_cfg.start_col + COORD_W'($urandom_range(tile_cfg.tile_cols - 1, 0));
    end else begin
      row = COORD_W'($urandom_range(4095, 0));
      col = COORD_W'($urandom_range(4095, 0));
    end
    queue_pixel(row, col, random_channel(), random_channel(), random_channel(), last);
  endtask

  function automatic logic [CFG_DW-1:0] random_dim();
    case ($urandom_range(19, 0))
      0:       return 0;
      1:       return 4096;
      2:       return $urandom_range(8191, 4097);  // beyond the nominal range
      3:       return $urandom_range(4096, 25);
      default: return $urandom_range(24, 1);
    endcase
  endfunction

  // Set bits above the register width now and then; the block must mask them off.
  function automatic logic [CFG_DW-1:0] with_junk(logic [CFG_DW-1:0] v, int w);
    if ($urandom_range(9, 0) == 0) return v | ($urandom << w);
    return v;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin : run_stimulus
    logic [CFG_DW-1:0] scratch;
    logic [CFG_DW-1:0] mode_pick;
    int unsigned       directed_items;
    int unsigned       frames;

    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    pix_ch.valid      = 1'b0;
    pix_ch.pixel_row  = '0;
    pix_ch.pixel_col  = '0;
    pix_ch.blue_in    = '0;
    pix_ch.green_in   = '0;
    pix_ch.red_in     = '0;
    pix_ch.frame_end  = 1'b0;
    mean_ch.ready     = 1'b0;
    tile_cfg          = '0;
    blue_total        = '0;
    green_total       = '0;
    red_total         = '0;
    pixels_queued     = 0;
    pixels_accepted   = 0;
    mismatch_count    = 0;
    in_taken          = 1'b0;
    send_gap          = 0;
    stall_left        = 0;
    idle_pct          = 20;
    calm_tail         = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers straight out of reset: zero tile, so the divisor is zero
    queue_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    settle();
    verify_registers();

    // Whole 2x2 rectangle at the origin, with one pixel that misses it
    program_tile(0, 0, 2, 2, MODE_RECT);
    queue_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(0, 1, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_pixel(1, 1, 8'hFF, 8'h00, 8'h80, 1'b0);
    queue_pixel(1, 0, 8'h01, 8'hFE, 8'h7F, 1'b1);
    settle();

    // Each triangle: one pixel on the diagonal, one on the anti-diagonal
    for (int m = MODE_TRI_UPPER; m <= MODE_TRI_LEFT; m++) begin
      program_tile(100, 200, 3, 3, m);
      queue_pixel(101, 201, 8'hC8, 8'h37, 8'hFF, 1'b0);
      queue_pixel(102, 200, 8'h10, 8'hFF, 8'h01, 1'b1);
      settle();
    end

    // Mask that counts nothing: means zero, divisor still halved and nonzero
    program_tile(100, 200, 3, 3, MODE_VOID_FIRST);
    queue_pixel(100, 200, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(101, 201, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    settle();

    // Tile running off the image: only the corner pixel is present
    program_tile(4094, 4094, 4096, 4096, MODE_RECT);
    queue_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(0, 0, 8'h01, 8'h02, 8'h03, 1'b1);
    settle();

    // 1x1 triangle halves to a zero divisor even though the pixel counts
    program_tile(7, 9, 1, 1, MODE_TRI_RIGHT);
    queue_pixel(7, 9, 8'h55, 8'hAA, 8'hFF, 1'b1);
    settle();

    // Repeat one pixel in a 1x1 tile to push the blue and green means past the 8.8 ceiling
    program_tile(0, 0, 1, 1, MODE_RECT);
    queue_pixel(0, 0, 8'hFF, 8'h80, 8'h01, 1'b0);
    queue_pixel(0, 0, 8'hFF, 8'h80, 8'h01, 1'b0);
    queue_pixel(0, 0, 8'hFF, 8'h80, 8'h01, 1'b1);
    settle();

    // All-ones writes: every register keeps only its own width; spare indexes do nothing
    program_tile('1, '1, '1, '1, '1);
    apb_cycle(1'b1, REG_SPARE_FIRST, $urandom, scratch);
    apb_cycle(1'b1, REG_SPARE_LAST, '1, scratch);
    verify_registers();
    queue_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    settle();
    program_tile('1, '1, '1, '1, MODE_RECT);
    queue_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    settle();

    directed_items = pixels_queued;

    // Random phases: new tile, a few frames, then drain before the next write.
    // The last tenth of the run has no idling on either side.
    while (pixels_queued < directed_items + RANDOM_ITEMS) begin
      calm_tail = (pixels_queued >= directed_items + RANDOM_ITEMS * 9 / 10);
      case ($urandom_range(3, 0))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 20;
        default: idle_pct = 40;
      endcase
      if ($urandom_range(99, 0) < 85) mode_pick = $urandom_range(MODE_TRI_LEFT, MODE_RECT);
      else mode_pick = $urandom_range(MODE_VOID_LAST, MODE_VOID_FIRST);
      program_tile(with_junk($urandom_range(4095, 0), COORD_W),
                   with_junk($urandom_range(4095, 0), COORD_W),
                   with_junk(random_dim(), DIM_W),
                   with_junk(random_dim(), DIM_W),
                   with_junk(mode_pick, MODE_W));
      frames = $urandom_range(4, 1);
      repeat (frames) begin
        repeat ($urandom_range(19, 0)) queue_random_pixel(1'b0);
        queue_random_pixel(1'b1);
      end
      // now and then leave a broken frame open; its sums carry into the next tile
      if ($urandom_range(7, 0) == 0) repeat ($urandom_range(5, 1)) queue_random_pixel(1'b0);
      settle();
    end

    // Close any frame left open, then drain
    queue_random_pixel(1'b1);
    settle();

    if (mismatch_count == 0 && expected_means.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
rtl/rac_pkg.sv
rtl/rac_if.sv
rtl/rac_cfg.sv
rtl/rac_fifo.sv
rtl/rac_front.sv
rtl/rac_back.sv
rtl/region_average_color.sv
rtl/rac_checker.sv
sim/region_average_color_test.sv
